// ===== src/ctfm_pkg.sv =====
// Shared types and constants for the color transfer function map.
// No dependencies; imported by ctfm_div and the top level.
package ctfm_pkg;

  localparam int unsigned NUM_POINTS = 6;
  localparam int unsigned VAL_W      = 16;

  // divider: restoring, DIV_BITS quotient bits per stage
  localparam int unsigned DIV_STAGES = 16;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned NUM_W      = DIV_STAGES * DIV_BITS;
  localparam int unsigned DEN_W      = VAL_W;

  // result buffer / request credits
  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned CH_RED   = 2;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 0;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [2:0][VAL_W-1:0] color_t;

  typedef struct packed {
    val_t   pos;
    color_t color;
  } point_t;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_NEAREST = 2'd1,
    MODE_LEFT    = 2'd2,
    MODE_BLACK   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MAP_MODE    = 3'd0,
    REG_POINT_COUNT = 3'd1,
    REG_POINT_0     = 3'd2,
    REG_POINT_1     = 3'd3,
    REG_POINT_2     = 3'd4,
    REG_POINT_3     = 3'd5,
    REG_POINT_4     = 3'd6,
    REG_POINT_5     = 3'd7
  } reg_e;

  typedef enum logic {
    CLS_COLOR  = 1'b0,
    CLS_LINEAR = 1'b1
  } cls_e;

  // travels alongside the divider lanes
  typedef struct packed {
    logic       valid;
    cls_e       cls;
    color_t     color;
    color_t     left;
    logic [2:0] neg;
  } side_t;

endpackage

// ===== src/ctfm_if.sv =====
// Request channel interfaces: sample in, color out.
// No dependencies.
interface ctfm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface ctfm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ===== src/ctfm_div.sv =====
// Pipelined three-lane unsigned restoring divider with sideband.
// Depends on ctfm_pkg.
module ctfm_div import ctfm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  side_t                       side_i,
  input  logic [2:0][NUM_W-1:0]       num_i,
  input  logic [DEN_W-1:0]            den_i,
  output side_t                       side_o,
  output logic [2:0][NUM_W-1:0]       quot_o
);

  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [2:0][DEN_W-1:0] rem;
    logic [DEN_W-1:0]      den;
  } lane_t;

  side_t side_q  [DIV_STAGES];
  lane_t lane_q  [DIV_STAGES];
  lane_t lane_d  [DIV_STAGES];
  side_t side_d  [DIV_STAGES];
  lane_t lane_in [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign lane_in[s] = '{num: num_i, rem: '0, den: den_i};
      assign side_d[s]  = side_i;
    end else begin : g_tail
      assign lane_in[s] = lane_q[s-1];
      assign side_d[s]  = side_q[s-1];
    end

    always_comb begin
      lane_t          cur;
      logic [DEN_W:0] trial;
      cur = lane_in[s];
      for (int c = 0; c < 3; c++) begin
        for (int b = 0; b < DIV_BITS; b++) begin
          trial      = {cur.rem[c], cur.num[c][NUM_W-1]};
          cur.num[c] = {cur.num[c][NUM_W-2:0], 1'b0};
          if (trial >= {1'b0, cur.den}) begin
            trial         = trial - {1'b0, cur.den};
            cur.num[c][0] = 1'b1;
          end
          cur.rem[c] = trial[DEN_W-1:0];
        end
      end
      lane_d[s] = cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else begin
        side_q[s] <= side_d[s];
      end
    end

    always_ff @(posedge clk_i) begin
      lane_q[s] <= lane_d[s];
    end
  end

  assign side_o = side_q[DIV_STAGES-1];
  assign quot_o = lane_q[DIV_STAGES-1].num;

endmodule

// ===== src/color_transfer_function_map_top.sv =====
// Piecewise-linear color map: sample request in, RGB request out.
// Depends on ctfm_pkg, ctfm_in_if, ctfm_out_if and ctfm_div.
//
// Usage:
//   sample_i carries one 16-bit sample per request; color_o returns one
//   RGB triple per sample, in order. Map mode, point count and the six
//   control points are written over the APB port while no request is in
//   flight; reads return the register contents.
// Pipeline: a sample passes 4 front stages, 16 divider stages, 1 result
//   stage and 1 buffer write before its color can be taken.
// Throughput: one sample per cycle while sample_i.ready is high; the
//   pipeline never stalls, the divider (16 stages of 2 quotient bits)
//   sets the depth.
// Back-pressure: a 32-entry result buffer sits after the pipeline, and
//   sample_i.ready stays high while fewer than 32 requests are in flight
//   or buffered, so a stalled receiver stops input at 32 outstanding.
// Reset: clears the pipeline and buffer; registers take their reset
//   values (linear mode, two points, black to white).
module color_transfer_function_map_top import ctfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctfm_in_if.sink           sample_i,
  ctfm_out_if.source        color_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  // ---------------- configuration ----------------
  mode_e      mode_q;
  logic [2:0] count_q;
  point_t     point_q [NUM_POINTS];
  logic       wr_en;
  reg_e       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINEAR;
      count_q <= 3'd2;
      for (int i = 0; i < NUM_POINTS; i++) begin
        point_q[i] <= (i == 1) ? '1 : '0;
      end
    end else if (wr_en) begin
      if (reg_idx == REG_MAP_MODE) begin
        mode_q <= mode_e'(pwdata[1:0]);
      end
      if (reg_idx == REG_POINT_COUNT) begin
        count_q <= pwdata[2:0];
      end
      for (int i = 0; i < NUM_POINTS; i++) begin
        if (paddr[5:3] == 3'(int'(REG_POINT_0) + i)) begin
          point_q[i] <= point_t'(pwdata);
        end
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAP_MODE:    prdata = 64'(mode_q);
      REG_POINT_COUNT: prdata = 64'(count_q);
      REG_POINT_0:     prdata = point_q[0];
      REG_POINT_1:     prdata = point_q[1];
      REG_POINT_2:     prdata = point_q[2];
      REG_POINT_3:     prdata = point_q[3];
      REG_POINT_4:     prdata = point_q[4];
      REG_POINT_5:     prdata = point_q[5];
      default:         prdata = '0;
    endcase
  end

  // ---------------- request credits ----------------
  logic               in_acc;
  logic               out_acc;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   fifo_cnt_q;
  logic [FIFO_AW-1:0] wr_ptr_q;
  logic [FIFO_AW-1:0] rd_ptr_q;
  color_t             fifo_q [FIFO_DEPTH];

  assign sample_i.ready = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign in_acc         = sample_i.valid & sample_i.ready;
  assign color_o.valid  = (fifo_cnt_q != '0);
  assign out_acc        = color_o.valid & color_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // ---------------- stage A: segment search ----------------
  logic [2:0] n_pts;
  logic [2:0] seg;
  val_t       smp;
  logic       lo_hit;
  logic       hi_hit;
  point_t     last_pt;

  logic   a_valid_q;
  logic   a_end_q;
  color_t a_end_col_q;
  val_t   a_smp_q;
  point_t a_lp_q;
  point_t a_rp_q;

  assign smp = sample_i.sample_value;

  always_comb begin
    if (count_q == '0) begin
      n_pts = 3'd1;
    end else if (count_q > 3'(NUM_POINTS)) begin
      n_pts = 3'(NUM_POINTS);
    end else begin
      n_pts = count_q;
    end
    last_pt = point_q[n_pts - 3'd1];
    lo_hit  = (smp <= point_q[0].pos);
    hi_hit  = (smp >= last_pt.pos);
    seg     = (n_pts == 3'd1) ? 3'd1 : n_pts - 3'd1;
    for (int i = NUM_POINTS - 2; i >= 1; i--) begin
      if (3'(i) < n_pts - 3'd1 && smp <= point_q[i].pos) begin
        seg = 3'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    a_end_q     <= lo_hit | hi_hit;
    a_end_col_q <= lo_hit ? point_q[0].color : last_pt.color;
    a_smp_q     <= smp;
    a_lp_q      <= point_q[seg - 3'd1];
    a_rp_q      <= point_q[seg];
  end

  // ---------------- stage B: offsets and deltas ----------------
  logic              b_valid_q;
  logic              b_end_q;
  color_t            b_end_col_q;
  color_t            b_left_q;
  color_t            b_right_q;
  logic signed [16:0] b_off_q;
  logic signed [16:0] b_span_q;
  logic signed [16:0] b_diff_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_end_q     <= a_end_q;
    b_end_col_q <= a_end_col_q;
    b_left_q    <= a_lp_q.color;
    b_right_q   <= a_rp_q.color;
    b_off_q     <= $signed({1'b0, a_smp_q}) - $signed({1'b0, a_lp_q.pos});
    b_span_q    <= $signed({1'b0, a_rp_q.pos}) - $signed({1'b0, a_lp_q.pos});
    for (int c = 0; c < 3; c++) begin
      b_diff_q[c] <= $signed({1'b0, a_rp_q.color[c]}) - $signed({1'b0, a_lp_q.color[c]});
    end
  end

  // ---------------- stage C: classify, multiply ----------------
  logic               below;
  logic signed [17:0] off2;
  cls_e               c_cls_d;
  color_t             c_col_d;

  logic               c_valid_q;
  cls_e               c_cls_q;
  color_t             c_col_q;
  color_t             c_left_q;
  logic signed [16:0] c_span_q;
  logic signed [33:0] c_prod_q [3];

  always_comb begin
    off2  = 18'(b_off_q) <<< 1;
    below = (b_span_q > 17'sd0) ? (off2 < 18'(b_span_q)) : (off2 > 18'(b_span_q));
    c_cls_d = CLS_COLOR;
    c_col_d = b_left_q;
    priority if (b_end_q) begin
      c_col_d = b_end_col_q;
    end else if (mode_q == MODE_BLACK) begin
      c_col_d = '0;
    end else if (b_span_q == '0 || mode_q == MODE_LEFT) begin
      c_col_d = b_left_q;
    end else if (mode_q == MODE_NEAREST) begin
      c_col_d = below ? b_left_q : b_right_q;
    end else begin
      c_cls_d = CLS_LINEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_cls_q  <= c_cls_d;
    c_col_q  <= c_col_d;
    c_left_q <= b_left_q;
    c_span_q <= b_span_q;
    for (int c = 0; c < 3; c++) begin
      c_prod_q[c] <= 34'(b_diff_q[c]) * 34'(b_off_q);
    end
  end

  // ---------------- stage D: sign and magnitude ----------------
  side_t                 d_side_q;
  logic [2:0][NUM_W-1:0] d_num_q;
  logic [DEN_W-1:0]      d_den_q;
  logic signed [16:0]    neg_span;
  logic signed [33:0]    neg_prod [3];

  always_comb begin
    neg_span = -c_span_q;
    for (int c = 0; c < 3; c++) begin
      neg_prod[c] = -c_prod_q[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_side_q <= '0;
    end else begin
      d_side_q.valid <= c_valid_q;
      d_side_q.cls   <= c_cls_q;
      d_side_q.color <= c_col_q;
      d_side_q.left  <= c_left_q;
      for (int c = 0; c < 3; c++) begin
        d_side_q.neg[c] <= c_prod_q[c][33] ^ c_span_q[16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_den_q <= c_span_q[16] ? neg_span[15:0] : c_span_q[15:0];
    for (int c = 0; c < 3; c++) begin
      d_num_q[c] <= c_prod_q[c][33] ? neg_prod[c][NUM_W-1:0] : c_prod_q[c][NUM_W-1:0];
    end
  end

  // ---------------- divider ----------------
  side_t                 q_side;
  logic [2:0][NUM_W-1:0] q_quot;

  ctfm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (d_side_q),
    .num_i  (d_num_q),
    .den_i  (d_den_q),
    .side_o (q_side),
    .quot_o (q_quot)
  );

  // ---------------- stage E: apply and saturate ----------------
  color_t         e_col_d;
  logic [NUM_W:0] sum;
  logic           e_valid_q;
  color_t         e_col_q;

  always_comb begin
    e_col_d = q_side.color;
    sum     = '0;
    if (q_side.cls == CLS_LINEAR) begin
      for (int c = 0; c < 3; c++) begin
        sum = {1'b0, q_quot[c]} + (NUM_W+1)'(q_side.left[c]);
        if (q_side.neg[c]) begin
          e_col_d[c] = (q_quot[c] > NUM_W'(q_side.left[c])) ? '0
                     : q_side.left[c] - q_quot[c][VAL_W-1:0];
        end else begin
          e_col_d[c] = (sum > (NUM_W+1)'({VAL_W{1'b1}})) ? '1 : sum[VAL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= q_side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    e_col_q <= e_col_d;
  end

  // ---------------- result buffer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (e_valid_q) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + CNT_W'(e_valid_q) - CNT_W'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_valid_q) begin
      fifo_q[wr_ptr_q] <= e_col_q;
    end
  end

  assign color_o.red_out   = fifo_q[rd_ptr_q][CH_RED];
  assign color_o.green_out = fifo_q[rd_ptr_q][CH_GREEN];
  assign color_o.blue_out  = fifo_q[rd_ptr_q][CH_BLUE];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("request count above buffer depth");

  a_fifo_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= cnt_q)
    else $error("buffered results exceed requests in flight");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q |-> (fifo_cnt_q < CNT_W'(FIFO_DEPTH)) || out_acc)
    else $error("result buffer overflow");

  a_credit_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_acc) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("request credit not taken");
`endif

endmodule
